>>> hdl/slpr_pkg.sv
// ----------------------------------------------------------------------------
// slpr_pkg
// Types, codes and the walk-count table builder for the split lattice path
// ranker.
// ----------------------------------------------------------------------------
package slpr_pkg;

   localparam int WORD_W   = 27;
   localparam int COUNT_W  = 4;
   localparam int POS_W    = 5;             // covers high + center + low counts
   localparam int HT_W     = 5;             // heights up to 1 + the longest walk
   localparam int MAX_HTS  = 2 ** HT_W;
   localparam int LEN_W    = 4;
   localparam int LEN_LEVELS = 15;
   localparam int TAB_LENS = 2 ** LEN_W;
   localparam int CNT_W    = 15;            // longest walk has 2^14 paths
   localparam int ACC_W    = 16;
   localparam int RANK_W   = 10;            // ranks below 1024
   localparam int END_W    = 4;             // end heights below 16
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 3;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEN   = 3'd1,
      ST_BELOW     = 3'd2,
      ST_LOW_NZ    = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      CENTER_NONE = 2'd0,
      CENTER_DOWN = 2'd1,
      CENTER_UP   = 2'd2
   } center_type;

   typedef struct packed {
      logic load;
      logic step_high;
      logic start_rank;
      logic step_rank;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic err;
      logic kh_zero;
      logic high_last;
      logic rank_last;
   } dp_status_type;

   typedef logic [TAB_LENS-1:0][MAX_HTS-1:0][MAX_HTS-1:0][CNT_W-1:0] walk_table_type;

   // Walk counts in a strip of the given number of heights; zero outside it.
   function automatic walk_table_type build_walks(input int levels);
      walk_table_type t;
      logic [CNT_W-1:0] z;
      t = '0;
      for (int s = 0; s < MAX_HTS; s++) begin
         if (s < levels) begin
            t[0][s][s] = CNT_W'(1);
         end
      end
      for (int len = 1; len < LEN_LEVELS; len++) begin
         for (int s = 0; s < MAX_HTS; s++) begin
            for (int e = 0; e < MAX_HTS; e++) begin
               if (s < levels && e < levels) begin
                  z = '0;
                  if (s > 0) begin
                     z = z + t[len-1][s-1][e];
                  end
                  if (s + 1 < levels) begin
                     z = z + t[len-1][s+1][e];
                  end
                  t[len][s][e] = z;
               end
            end
         end
      end
      return t;
   endfunction

endpackage

>>> hdl/slpr_ctrl.sv
// ----------------------------------------------------------------------------
// slpr_ctrl
// Sequencer for the ranker: accept, height pass, ranking pass, final check
// and the result register's valid flag.
// ----------------------------------------------------------------------------
module slpr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  slpr_pkg::dp_status_type dp_status,
   output slpr_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_START  = 7'b0000010,
      S_HSCAN  = 7'b0000100,
      S_RSTART = 7'b0001000,
      S_RANK   = 7'b0010000,
      S_FLUSH  = 7'b0100000,
      S_CHECK  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (dp_status.err) begin
               state_in = S_CHECK;
            end else if (dp_status.kh_zero) begin
               cmd.start_rank = 1'b1;
               state_in       = S_RANK;
            end else begin
               state_in = S_HSCAN;
            end
         end
         S_HSCAN: begin
            if (dp_status.err) begin
               state_in = S_CHECK;
            end else begin
               cmd.step_high = 1'b1;
               if (dp_status.high_last) begin
                  state_in = S_RSTART;
               end
            end
         end
         S_RSTART: begin
            if (dp_status.err) begin
               state_in = S_CHECK;
            end else begin
               cmd.start_rank = 1'b1;
               state_in       = S_RANK;
            end
         end
         S_RANK: begin
            if (dp_status.err) begin
               state_in = S_CHECK;
            end else begin
               cmd.step_rank = 1'b1;
               if (dp_status.rank_last) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            // last table read lands in the accumulator here
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> hdl/slpr_dpath.sv
// ----------------------------------------------------------------------------
// slpr_dpath
// Datapath: captured transaction, height walker, walk-count ROM with
// registered read, rank accumulators, final check and result register.
// ----------------------------------------------------------------------------
module slpr_dpath #(
   parameter int HIGH_MAX      = 13,
   parameter int LOW_MAX       = 14,
   parameter int HEIGHT_LEVELS = 17
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  slpr_pkg::ctrl_cmd_type                cmd,
   output slpr_pkg::dp_status_type               dp_status,
   input  logic [slpr_pkg::WORD_W-1:0]           req_path_word,
   input  logic [slpr_pkg::COUNT_W-1:0]          req_high_count,
   input  logic                                  req_center_present,
   input  logic [slpr_pkg::COUNT_W-1:0]          req_low_count,
   output logic [slpr_pkg::END_W-1:0]            rsp_end_height,
   output logic [slpr_pkg::KIND_W-1:0]           rsp_center_kind,
   output logic [slpr_pkg::RANK_W-1:0]           rsp_high_rank,
   output logic [slpr_pkg::RANK_W-1:0]           rsp_low_rank,
   output logic [slpr_pkg::STAT_W-1:0]           rsp_status
);

   localparam slpr_pkg::walk_table_type WalkTable = slpr_pkg::build_walks(HEIGHT_LEVELS);
   localparam int ExtW = 2 ** slpr_pkg::POS_W;

   // captured transaction
   logic [slpr_pkg::WORD_W-1:0]  word_ff;
   logic [slpr_pkg::POS_W-1:0]   m_ff, split_ff, kl_ff;
   logic                         cp_ff, kh_zero_ff;

   // walker
   logic [slpr_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [slpr_pkg::HT_W-1:0]    cur_ff, cur_in, he_ff, he_in;
   slpr_pkg::status_type         status_ff, status_in;
   slpr_pkg::center_type         center_ff, center_in;

   // table read and accumulate
   logic [slpr_pkg::LEN_W-1:0]   rom_len;
   logic [slpr_pkg::HT_W-1:0]    rom_s, rom_e;
   logic                         rom_rd;
   logic [slpr_pkg::CNT_W-1:0]   rom_data_ff;
   logic                         add_en_ff, add_en_in, add_low_ff, add_low_in;
   logic [slpr_pkg::ACC_W-1:0]   hr_ff, hr_in, lr_ff, lr_in;
   logic                         hr_ovf_ff, hr_ovf_in, lr_ovf_ff, lr_ovf_in;
   logic [slpr_pkg::ACC_W:0]     acc_sum;

   // result register
   logic [slpr_pkg::END_W-1:0]   out_end_ff;
   logic [slpr_pkg::KIND_W-1:0]  out_kind_ff;
   logic [slpr_pkg::RANK_W-1:0]  out_hr_ff, out_lr_ff;
   logic [slpr_pkg::STAT_W-1:0]  out_stat_ff;

   logic [slpr_pkg::POS_W-1:0]   req_m;
   logic                         req_bad;
   logic [ExtW-1:0]              word_ext;
   logic                         bit_down, in_high, in_center;
   logic [slpr_pkg::POS_W-1:0]   high_rem;
   slpr_pkg::status_type         final_status;

   assign req_m = slpr_pkg::POS_W'(req_high_count) + slpr_pkg::POS_W'(req_center_present)
                + slpr_pkg::POS_W'(req_low_count);
   assign req_bad = (req_m == '0) || !req_m[0]
                 || (slpr_pkg::POS_W'(req_high_count) > slpr_pkg::POS_W'(HIGH_MAX))
                 || (slpr_pkg::POS_W'(req_low_count) > slpr_pkg::POS_W'(LOW_MAX));

   // bits above the word read as up steps
   assign word_ext  = ExtW'(word_ff);
   assign bit_down  = word_ext[pos_ff];
   assign in_high   = (pos_ff >= split_ff);
   assign in_center = cp_ff && (pos_ff == kl_ff);
   assign high_rem  = pos_ff - split_ff;

   assign dp_status.err       = (status_ff != slpr_pkg::ST_OK);
   assign dp_status.kh_zero   = kh_zero_ff;
   assign dp_status.high_last = (pos_ff == split_ff);
   assign dp_status.rank_last = (pos_ff == '0);

   always_comb begin
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      he_in      = he_ff;
      status_in  = status_ff;
      center_in  = center_ff;
      rom_rd     = 1'b0;
      add_low_in = !in_high;
      rom_len    = in_high ? high_rem[slpr_pkg::LEN_W-1:0] : pos_ff[slpr_pkg::LEN_W-1:0];
      rom_s      = cur_ff - 1'b1;
      rom_e      = in_high ? he_ff : '0;
      if (cmd.load) begin
         pos_in    = req_m - 1'b1;
         cur_in    = slpr_pkg::HT_W'(1);
         he_in     = slpr_pkg::HT_W'(1);
         center_in = slpr_pkg::CENTER_NONE;
         status_in = req_bad ? slpr_pkg::ST_BAD_LEN : slpr_pkg::ST_OK;
      end else if (cmd.start_rank) begin
         he_in  = cur_ff;
         cur_in = slpr_pkg::HT_W'(1);
         pos_in = m_ff - 1'b1;
      end else if ((cmd.step_high || cmd.step_rank) && status_ff == slpr_pkg::ST_OK) begin
         pos_in = pos_ff - 1'b1;
         if (bit_down) begin
            if (cur_ff == '0) begin
               status_in = slpr_pkg::ST_BELOW;
            end else begin
               cur_in = cur_ff - 1'b1;
            end
         end else begin
            cur_in = cur_ff + 1'b1;
            rom_rd = cmd.step_rank && (cur_ff != '0) && !in_center;
         end
         if (cmd.step_rank && in_center) begin
            center_in = bit_down ? slpr_pkg::CENTER_DOWN : slpr_pkg::CENTER_UP;
         end
      end
   end

   assign add_en_in = rom_rd;

   always_comb begin
      hr_in     = hr_ff;
      lr_in     = lr_ff;
      hr_ovf_in = hr_ovf_ff;
      lr_ovf_in = lr_ovf_ff;
      acc_sum   = (add_low_ff ? {1'b0, lr_ff} : {1'b0, hr_ff})
                + (slpr_pkg::ACC_W + 1)'(rom_data_ff);
      if (cmd.load) begin
         hr_in     = '0;
         lr_in     = '0;
         hr_ovf_in = 1'b0;
         lr_ovf_in = 1'b0;
      end else if (add_en_ff) begin
         if (add_low_ff) begin
            lr_in     = acc_sum[slpr_pkg::ACC_W-1:0];
            lr_ovf_in = lr_ovf_ff | acc_sum[slpr_pkg::ACC_W];
         end else begin
            hr_in     = acc_sum[slpr_pkg::ACC_W-1:0];
            hr_ovf_in = hr_ovf_ff | acc_sum[slpr_pkg::ACC_W];
         end
      end
   end

   always_comb begin
      final_status = status_ff;
      if (status_ff == slpr_pkg::ST_OK) begin
         if (cur_ff != '0) begin
            final_status = slpr_pkg::ST_LOW_NZ;
         end else if (hr_ovf_ff || lr_ovf_ff
                      || (hr_ff[slpr_pkg::ACC_W-1:slpr_pkg::RANK_W] != '0)
                      || (lr_ff[slpr_pkg::ACC_W-1:slpr_pkg::RANK_W] != '0)
                      || (he_ff[slpr_pkg::HT_W-1:slpr_pkg::END_W] != '0)) begin
            final_status = slpr_pkg::ST_OVERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= slpr_pkg::ST_OK;
         add_en_ff <= 1'b0;
      end else begin
         status_ff <= status_in;
         add_en_ff <= add_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff    <= req_path_word;
         m_ff       <= req_m;
         kl_ff      <= slpr_pkg::POS_W'(req_low_count);
         split_ff   <= slpr_pkg::POS_W'(req_low_count) + slpr_pkg::POS_W'(req_center_present);
         cp_ff      <= req_center_present;
         kh_zero_ff <= (req_high_count == '0);
      end
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      he_ff       <= he_in;
      center_ff   <= center_in;
      add_low_ff  <= add_low_in;
      hr_ff       <= hr_in;
      lr_ff       <= lr_in;
      hr_ovf_ff   <= hr_ovf_in;
      lr_ovf_ff   <= lr_ovf_in;
      rom_data_ff <= WalkTable[rom_len][rom_s][rom_e];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_stat_ff <= final_status;
         if (final_status == slpr_pkg::ST_OK) begin
            out_end_ff  <= he_ff[slpr_pkg::END_W-1:0];
            out_kind_ff <= center_ff;
            out_hr_ff   <= hr_ff[slpr_pkg::RANK_W-1:0];
            out_lr_ff   <= lr_ff[slpr_pkg::RANK_W-1:0];
         end else begin
            out_end_ff  <= '0;
            out_kind_ff <= slpr_pkg::CENTER_NONE;
            out_hr_ff   <= '0;
            out_lr_ff   <= '0;
         end
      end
   end

   assign rsp_end_height  = out_end_ff;
   assign rsp_center_kind = out_kind_ff;
   assign rsp_high_rank   = out_hr_ff;
   assign rsp_low_rank    = out_lr_ff;
   assign rsp_status      = out_stat_ff;

endmodule

>>> hdl/split_lattice_path_ranker.sv
// ----------------------------------------------------------------------------
// split_lattice_path_ranker
// Ranks a split up/down word: end height of the high segment, center kind,
// and ranks of the high and low segments among non-negative walks.
// ----------------------------------------------------------------------------
// Usage: present a word on req_* with req_valid; the transaction is taken when
// req_stall is low. req_stall stays high while a word is being worked on.
// One pass walks the high segment to find its end height, a second pass walks
// every terminal, one bit a cycle, reading the walk-count ROM and adding the
// registered count in the next cycle.
// A bad length or a walk below zero ends the word early and reports its
// status; a new word is taken only once the current one is finished.
// The result sits in an output register: rsp_* holds while rsp_stall is high,
// and the next word is already accepted and worked on meanwhile; the final
// write waits for the register to free.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid; the walk-count table is constant and needs no fill.
// ----------------------------------------------------------------------------
module split_lattice_path_ranker #(
   parameter int HIGH_MAX      = 13,
   parameter int LOW_MAX       = 14,
   parameter int HEIGHT_LEVELS = 17
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [slpr_pkg::WORD_W-1:0]  req_path_word,
   input  logic [slpr_pkg::COUNT_W-1:0] req_high_count,
   input  logic                         req_center_present,
   input  logic [slpr_pkg::COUNT_W-1:0] req_low_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [slpr_pkg::END_W-1:0]   rsp_end_height,
   output logic [slpr_pkg::KIND_W-1:0]  rsp_center_kind,
   output logic [slpr_pkg::RANK_W-1:0]  rsp_high_rank,
   output logic [slpr_pkg::RANK_W-1:0]  rsp_low_rank,
   output logic [slpr_pkg::STAT_W-1:0]  rsp_status
);

   slpr_pkg::ctrl_cmd_type  cmd;
   slpr_pkg::dp_status_type dp_status;

   slpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   slpr_dpath #(
      .HIGH_MAX      (HIGH_MAX),
      .LOW_MAX       (LOW_MAX),
      .HEIGHT_LEVELS (HEIGHT_LEVELS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .dp_status          (dp_status),
      .req_path_word      (req_path_word),
      .req_high_count     (req_high_count),
      .req_center_present (req_center_present),
      .req_low_count      (req_low_count),
      .rsp_end_height     (rsp_end_height),
      .rsp_center_kind    (rsp_center_kind),
      .rsp_high_rank      (rsp_high_rank),
      .rsp_low_rank       (rsp_low_rank),
      .rsp_status         (rsp_status)
   );

endmodule
